[design/at_command_modem_interpreter_assert.svh]
// Assertion macros used by the interpreter executor (atcmi_exec).
`ifndef AT_COMMAND_MODEM_INTERPRETER_ASSERT_SVH
`define AT_COMMAND_MODEM_INTERPRETER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ATCMI_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("atcmi check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ATCMI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("atcmi check failed");

`endif

[design/atcmi_pkg.sv]
package atcmi_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 32;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned DIAL_MAX       = 32;
  localparam int unsigned MSG_MAX        = 18;
  localparam logic [15:0] GUARD_RESET    = 16'd1000;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    ACT_HOST  = 2'd0,
    ACT_NET   = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_CALL  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    KIND_HOST   = 3'd0,
    KIND_NET    = 3'd1,
    KIND_DIAL   = 3'd2,
    KIND_HANGUP = 3'd3,
    KIND_LON    = 3'd4,
    KIND_LOFF   = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    MSG_NONE    = 4'd0,
    MSG_EMPTY   = 4'd1,
    MSG_OK      = 4'd2,
    MSG_ERROR   = 4'd3,
    MSG_AA_ON   = 4'd4,
    MSG_AA_OFF  = 4'd5,
    MSG_CONNECT = 4'd6,
    MSG_BUSY    = 4'd7,
    MSG_NODT    = 4'd8,
    MSG_NOCAR   = 4'd9
  } msg_t;

  typedef struct packed {
    act_t        act;
    logic [7:0]  data;
    logic [31:0] now_ms;
    logic        write_ok;
    logic [1:0]  outcome;
    logic        listen_ok;
    logic        is_bs;
    logic        is_cr;
  } job_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       last;
    logic       carrier;
    logic       ready_res;
    logic       in_escape;
  } res_t;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [4:0] msg_len(msg_t id);
    logic [4:0] n;
    case (id)
      MSG_EMPTY:   n = 5'd2;
      MSG_OK:      n = 5'd6;
      MSG_ERROR:   n = 5'd9;
      MSG_AA_ON:   n = 5'd17;
      MSG_AA_OFF:  n = 5'd18;
      MSG_CONNECT: n = 5'd11;
      MSG_BUSY:    n = 5'd8;
      MSG_NODT:    n = 5'd15;
      MSG_NOCAR:   n = 5'd14;
      default:     n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] msg_char(msg_t id, logic [4:0] idx);
    logic [8*MSG_MAX-1:0] s;
    logic [4:0]           sh;
    case (id)
      MSG_EMPTY:   s = "\r\n";
      MSG_OK:      s = "\r\nOK\r\n";
      MSG_ERROR:   s = "\r\nERROR\r\n";
      MSG_AA_ON:   s = "\r\nAUTOANSWER ON\r\n";
      MSG_AA_OFF:  s = "\r\nAUTOANSWER OFF\r\n";
      MSG_CONNECT: s = "\r\nCONNECT\r\n";
      MSG_BUSY:    s = "\r\nBUSY\r\n";
      MSG_NODT:    s = "\r\nNO DIALTONE\r\n";
      MSG_NOCAR:   s = "\r\nNO CARRIER\r\n";
      default:     s = '0;
    endcase
    sh = msg_len(id) - 5'd1 - idx;
    return s[{sh, 3'b000} +: 8];
  endfunction

endpackage

[design/atcmi_front.sv]
module atcmi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_data,
  input  logic [31:0]      in_now_ms,
  input  logic             in_write_ok,
  input  logic [1:0]       in_dial_outcome,
  input  logic             in_listen_ok,
  output logic             job_valid,
  output atcmi_pkg::job_t  job,
  input  logic             job_take
);
  import atcmi_pkg::*;

  job_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en;
  job_t       wr_job;

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign wr_en     = push && !full;

  always_comb begin
    wr_job.act       = act_t'(in_action);
    wr_job.data      = in_data;
    wr_job.now_ms    = in_now_ms;
    wr_job.write_ok  = in_write_ok;
    wr_job.outcome   = in_dial_outcome;
    wr_job.listen_ok = in_listen_ok;
    wr_job.is_bs     = (in_data == CH_BS) || (in_data == CH_DEL) || (in_data == CH_TILDE);
    wr_job.is_cr     = (in_data == CH_CR);
  end

  always_comb begin
    wp_nxt  = wp_r ^ wr_en;
    rp_nxt  = rp_r ^ (job_take && job_valid);
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, job_take && job_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= wr_job;
    end
  end

endmodule

[design/atcmi_outq.sv]
module atcmi_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             oq_push,
  input  atcmi_pkg::res_t  oq_data,
  output logic             oq_full,
  output logic             empty,
  input  logic             pop,
  output atcmi_pkg::res_t  head
);
  import atcmi_pkg::*;

  res_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign oq_full = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = q_r[rp_r];
  assign wr_en   = oq_push && !oq_full;
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ wr_en;
      rp_r  <= rp_r ^ rd_en;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= oq_data;
    end
  end

endmodule

[design/atcmi_exec.sv]
`include "at_command_modem_interpreter_assert.svh"
module atcmi_exec #(
  parameter int unsigned LINE_DEPTH = atcmi_pkg::LINE_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = atcmi_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  logic             job_valid,
  input  atcmi_pkg::job_t  job,
  output logic             job_take,
  output logic             oq_push,
  output atcmi_pkg::res_t  oq_data,
  input  logic             oq_full
);
  import atcmi_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  localparam logic [2:0] POS_BYTE = 3'd0;
  localparam logic [2:0] POS_CTRL = 3'd1;
  localparam logic [2:0] POS_DIAL = 3'd2;
  localparam logic [2:0] POS_MSG  = 3'd3;
  localparam logic [2:0] POS_POST = 3'd4;

  localparam logic [1:0] VP_LEAD = 2'd0;
  localparam logic [1:0] VP_DIG  = 2'd1;
  localparam logic [1:0] VP_DONE = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCAN   = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_BYTE   = 9'b000001000,
    ST_CTRL   = 9'b000010000,
    ST_DREQ   = 9'b000100000,
    ST_DOUT   = 9'b001000000,
    ST_MSG    = 9'b010000000,
    ST_POST   = 9'b100000000
  } state_t;

  function automatic state_t seg_from(logic [2:0] pos, logic pb, logic pc, logic dnz,
                                      logic pm, logic pp);
    state_t s;
    s = ST_IDLE;
    if (pos <= POS_POST && pp) s = ST_POST;
    if (pos <= POS_MSG && pm) s = ST_MSG;
    if (pos <= POS_DIAL && dnz) s = ST_DREQ;
    if (pos <= POS_CTRL && pc) s = ST_CTRL;
    if (pos == POS_BYTE && pb) s = ST_BYTE;
    return s;
  endfunction

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(LINE_DEPTH)) s = s - (AW+1)'(LINE_DEPTH);
    return s[AW-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        count_r, count_nxt;
  logic                 online_r, online_nxt;
  logic                 ans_r, ans_nxt;
  logic                 esc_r, esc_nxt;
  logic [7:0]           rb_r [4];
  logic [7:0]           rb_nxt [4];
  logic [TIME_BITS-1:0] rt_r [4];
  logic [TIME_BITS-1:0] rt_nxt [4];
  logic [15:0]          guard_r, guard_nxt;
  logic [AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic                 stop_r, stop_nxt;
  logic [5:0]           k_r, k_nxt;

  logic [AW-1:0]        n_r, n_nxt;
  logic [AW-1:0]        neff_r, neff_nxt;
  logic [7:0]           pfx_r [5];
  logic [7:0]           pfx_nxt [5];
  logic [1:0]           vp_st_r, vp_st_nxt;
  logic                 vp_pos_r, vp_pos_nxt;
  logic                 df_found_r, df_found_nxt;
  logic [AW-1:0]        df_r, df_nxt;
  logic [AW-1:0]        dl_r, dl_nxt;
  logic [1:0]           jout_r, jout_nxt;
  logic                 jlok_r, jlok_nxt;
  logic                 pb_v_r, pb_v_nxt;
  kind_t                pb_kind_r, pb_kind_nxt;
  logic [7:0]           pb_byte_r, pb_byte_nxt;
  logic                 pc_v_r, pc_v_nxt;
  kind_t                pc_kind_r, pc_kind_nxt;
  logic [5:0]           dcnt_r, dcnt_nxt;
  msg_t                 msg_r, msg_nxt;
  logic                 post_r, post_nxt;

  logic [7:0]           line_mem [LINE_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [7:0]           mem_wdata;

  logic [TIME_BITS-1:0] t_new, tdiff;
  logic [AW-1:0]        cnt_app;
  logic [7:0]           c, lc;
  logic                 ws, dig, incl;
  logic                 at_pre, is_at, is_ata, is_ato, is_ath0, is_ath1, is_s0q;
  logic                 pre_z, pre_f, pre_d, pre_s0eq, tp, dempty;
  logic [AW-1:0]        dstart, ddiff;
  logic [AW:0]          dcntf;
  logic                 lastd, lastm;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    online_nxt   = online_r;
    ans_nxt      = ans_r;
    esc_nxt      = esc_r;
    rb_nxt       = rb_r;
    rt_nxt       = rt_r;
    guard_nxt    = cfg_we ? cfg_wdata : guard_r;
    rd_idx_nxt   = rd_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    stop_nxt     = stop_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    neff_nxt     = neff_r;
    pfx_nxt      = pfx_r;
    vp_st_nxt    = vp_st_r;
    vp_pos_nxt   = vp_pos_r;
    df_found_nxt = df_found_r;
    df_nxt       = df_r;
    dl_nxt       = dl_r;
    jout_nxt     = jout_r;
    jlok_nxt     = jlok_r;
    pb_v_nxt     = pb_v_r;
    pb_kind_nxt  = pb_kind_r;
    pb_byte_nxt  = pb_byte_r;
    pc_v_nxt     = pc_v_r;
    pc_kind_nxt  = pc_kind_r;
    dcnt_nxt     = dcnt_r;
    msg_nxt      = msg_r;
    post_nxt     = post_r;
    job_take     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wrap_add(head_r, count_r);
    mem_wdata    = job.data;
    mem_re       = 1'b0;
    mem_raddr    = wrap_add(head_r, rd_idx_r);
    oq_push      = 1'b0;
    oq_data.kind      = KIND_HOST;
    oq_data.byte_out  = 8'd0;
    oq_data.last      = 1'b0;
    oq_data.carrier   = online_r;
    oq_data.ready_res = online_r || ans_r;
    oq_data.in_escape = esc_r;
    t_new   = TIME_BITS'(job.now_ms);
    tdiff   = t_new - rt_r[1];
    cnt_app = (count_r == AW'(LINE_DEPTH - 1)) ? count_r : count_r + AW'(1);
    c       = rd_data_r;
    lc      = to_lower(rd_data_r);
    ws      = (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    dig     = (c >= "0") && (c <= "9");
    incl    = (pend_idx_r > AW'(3)) ||
              (pend_idx_r == AW'(3) && !(lc == "t" || lc == "p"));
    at_pre   = (pfx_r[0] == "a") && (pfx_r[1] == "t");
    is_at    = (neff_r == AW'(2)) && at_pre;
    is_ata   = (neff_r == AW'(3)) && at_pre && (pfx_r[2] == "a");
    is_ato   = (neff_r == AW'(3)) && at_pre && (pfx_r[2] == "o");
    is_ath0  = (neff_r == AW'(4)) && at_pre && (pfx_r[2] == "h") && (pfx_r[3] == "0");
    is_ath1  = (neff_r == AW'(4)) && at_pre && (pfx_r[2] == "h") && (pfx_r[3] == "1");
    pre_z    = (neff_r >= AW'(3)) && at_pre && (pfx_r[2] == "z");
    pre_d    = (neff_r >= AW'(3)) && at_pre && (pfx_r[2] == "d");
    pre_f    = (neff_r >= AW'(4)) && at_pre && (pfx_r[2] == "&") && (pfx_r[3] == "f");
    pre_s0eq = (neff_r >= AW'(5)) && at_pre && (pfx_r[2] == "s") && (pfx_r[3] == "0") &&
               (pfx_r[4] == "=");
    is_s0q   = (neff_r == AW'(5)) && at_pre && (pfx_r[2] == "s") && (pfx_r[3] == "0") &&
               (pfx_r[4] == "?");
    tp       = (neff_r > AW'(3)) && (pfx_r[3] == "t" || pfx_r[3] == "p");
    dstart   = tp ? AW'(4) : AW'(3);
    dempty   = (neff_r <= dstart);
    ddiff    = dl_r - df_r;
    dcntf    = {1'b0, ddiff} + (AW+1)'(1);
    lastd    = (k_r == dcnt_r - 6'd1);
    lastm    = (k_r == {1'b0, msg_len(msg_r) - 5'd1});

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          pb_v_nxt = 1'b0;
          pc_v_nxt = 1'b0;
          dcnt_nxt = 6'd0;
          msg_nxt  = MSG_NONE;
          post_nxt = 1'b0;
          k_nxt    = 6'd0;
          pb_byte_nxt = job.data;
          case (job.act)
            ACT_HOST: begin
              if (online_r && !esc_r) begin
                pb_v_nxt    = 1'b1;
                pb_kind_nxt = KIND_NET;
                if (!job.write_ok) begin
                  online_nxt  = 1'b0;
                  esc_nxt     = 1'b0;
                  pc_v_nxt    = 1'b1;
                  pc_kind_nxt = KIND_HANGUP;
                  msg_nxt     = MSG_NOCAR;
                end
                rb_nxt[0] = rb_r[1];
                rb_nxt[1] = rb_r[2];
                rb_nxt[2] = rb_r[3];
                rb_nxt[3] = job.data;
                rt_nxt[0] = rt_r[1];
                rt_nxt[1] = rt_r[2];
                rt_nxt[2] = rt_r[3];
                rt_nxt[3] = t_new;
                if (rb_r[2] == CH_PLUS && rb_r[3] == CH_PLUS && job.data == CH_PLUS &&
                    tdiff > TIME_BITS'(guard_r)) begin
                  esc_nxt = 1'b1;
                end
              end else begin
                mem_we = 1'b1;
                if (count_r == AW'(LINE_DEPTH - 1)) begin
                  head_nxt = wrap_add(head_r, AW'(1));
                end
                if (job.is_bs) begin
                  count_nxt = (cnt_app >= AW'(2)) ? cnt_app - AW'(2) : '0;
                end else if (job.is_cr) begin
                  count_nxt    = '0;
                  n_nxt        = cnt_app - AW'(1);
                  neff_nxt     = cnt_app - AW'(1);
                  rd_idx_nxt   = '0;
                  pend_v_nxt   = 1'b0;
                  stop_nxt     = 1'b0;
                  vp_st_nxt    = VP_LEAD;
                  vp_pos_nxt   = 1'b0;
                  df_found_nxt = 1'b0;
                  jout_nxt     = job.outcome;
                  jlok_nxt     = job.listen_ok;
                end else begin
                  count_nxt   = cnt_app;
                  pb_v_nxt    = 1'b1;
                  pb_kind_nxt = KIND_HOST;
                end
              end
            end
            ACT_NET: begin
              if (online_r && !esc_r) begin
                pb_v_nxt    = 1'b1;
                pb_kind_nxt = KIND_HOST;
              end
            end
            ACT_CLOSE: begin
              if (online_r && !esc_r) begin
                online_nxt  = 1'b0;
                esc_nxt     = 1'b0;
                pc_v_nxt    = 1'b1;
                pc_kind_nxt = KIND_HANGUP;
                msg_nxt     = MSG_NOCAR;
              end
            end
            ACT_CALL: begin
              if (!online_r && ans_r) begin
                online_nxt = 1'b1;
                msg_nxt    = MSG_CONNECT;
              end
            end
            default: ;
          endcase
          if (job.act == ACT_HOST && !(online_r && !esc_r) && job.is_cr) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = seg_from(POS_BYTE, pb_v_nxt, pc_v_nxt, 1'b0, msg_nxt != MSG_NONE,
                                 1'b0);
          end
        end
      end

      ST_SCAN: begin
        if (pend_v_r && !stop_r) begin
          if (c == 8'd0) begin
            stop_nxt = 1'b1;
            neff_nxt = pend_idx_r;
          end else begin
            if (pend_idx_r < AW'(5)) begin
              pfx_nxt[pend_idx_r[2:0]] = lc;
            end else begin
              case (vp_st_r)
                VP_LEAD: begin
                  if (ws) begin
                    vp_st_nxt = VP_LEAD;
                  end else if (c == CH_PLUS) begin
                    vp_st_nxt = VP_DIG;
                  end else if (dig && c != "0") begin
                    vp_st_nxt  = VP_DONE;
                    vp_pos_nxt = 1'b1;
                  end else if (dig) begin
                    vp_st_nxt = VP_DIG;
                  end else begin
                    vp_st_nxt = VP_DONE;
                  end
                end
                VP_DIG: begin
                  if (dig && c != "0") begin
                    vp_st_nxt  = VP_DONE;
                    vp_pos_nxt = 1'b1;
                  end else if (!dig) begin
                    vp_st_nxt = VP_DONE;
                  end
                end
                default: ;
              endcase
            end
            if (incl && c != CH_SP) begin
              if (!df_found_r) begin
                df_found_nxt = 1'b1;
                df_nxt       = pend_idx_r;
              end
              dl_nxt = pend_idx_r;
            end
          end
        end
        if (rd_idx_r < n_r && !stop_r) begin
          mem_re       = 1'b1;
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + AW'(1);
        end else begin
          pend_v_nxt = 1'b0;
        end
        if ((!pend_v_r || stop_r) && (rd_idx_r >= n_r || stop_r)) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (esc_r) begin
          if (neff_r == '0) begin
            msg_nxt = MSG_EMPTY;
          end else if (is_ata || is_ato || is_ath1) begin
            esc_nxt = 1'b0;
          end else if (is_ath0 || pre_z) begin
            online_nxt  = 1'b0;
            esc_nxt     = 1'b0;
            pc_v_nxt    = 1'b1;
            pc_kind_nxt = KIND_HANGUP;
            msg_nxt     = MSG_OK;
          end else begin
            msg_nxt = MSG_ERROR;
          end
        end else if (neff_r == '0) begin
          msg_nxt = MSG_EMPTY;
        end else if (is_at) begin
          msg_nxt = MSG_OK;
        end else if (is_ata || (pre_s0eq && vp_pos_r)) begin
          if (!ans_r && jlok_r) begin
            ans_nxt     = 1'b1;
            pc_v_nxt    = 1'b1;
            pc_kind_nxt = KIND_LON;
          end
          msg_nxt = (ans_r || jlok_r) ? MSG_AA_ON : MSG_ERROR;
        end else if (pre_s0eq) begin
          if (ans_r) begin
            ans_nxt     = 1'b0;
            pc_v_nxt    = 1'b1;
            pc_kind_nxt = KIND_LOFF;
          end
          msg_nxt = MSG_AA_OFF;
        end else if (is_s0q) begin
          msg_nxt = ans_r ? MSG_AA_ON : MSG_AA_OFF;
        end else if (is_ath0) begin
          online_nxt  = 1'b0;
          esc_nxt     = 1'b0;
          pc_v_nxt    = 1'b1;
          pc_kind_nxt = KIND_HANGUP;
          msg_nxt     = MSG_OK;
        end else if (is_ath1 || pre_z || pre_f) begin
          msg_nxt = MSG_OK;
        end else if (pre_d) begin
          if (dempty) begin
            msg_nxt = MSG_ERROR;
          end else begin
            if (!df_found_r) begin
              dcnt_nxt = 6'd0;
            end else if (int'(dcntf) > DIAL_MAX) begin
              dcnt_nxt = 6'(DIAL_MAX);
            end else begin
              dcnt_nxt = 6'(dcntf);
            end
            if (jout_r == 2'd0) begin
              online_nxt = 1'b1;
              msg_nxt    = MSG_CONNECT;
            end else begin
              online_nxt = 1'b0;
              esc_nxt    = 1'b0;
              post_nxt   = 1'b1;
              msg_nxt    = (jout_r == 2'd1) ? MSG_BUSY : MSG_NODT;
            end
          end
        end else begin
          msg_nxt = MSG_ERROR;
        end
        state_nxt = seg_from(POS_BYTE, 1'b0, pc_v_nxt, dcnt_nxt != 6'd0,
                             msg_nxt != MSG_NONE, post_nxt);
      end

      ST_BYTE: begin
        oq_push          = !oq_full;
        oq_data.kind     = pb_kind_r;
        oq_data.byte_out = pb_byte_r;
        oq_data.last     = seg_from(POS_CTRL, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                                    msg_r != MSG_NONE, post_r) == ST_IDLE;
        if (!oq_full) begin
          state_nxt = seg_from(POS_CTRL, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                               msg_r != MSG_NONE, post_r);
        end
      end

      ST_CTRL: begin
        oq_push      = !oq_full;
        oq_data.kind = pc_kind_r;
        oq_data.last = seg_from(POS_DIAL, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                                msg_r != MSG_NONE, post_r) == ST_IDLE;
        if (!oq_full) begin
          state_nxt = seg_from(POS_DIAL, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                               msg_r != MSG_NONE, post_r);
        end
      end

      ST_DREQ: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_r, df_r + AW'(k_r));
        state_nxt = ST_DOUT;
      end

      ST_DOUT: begin
        oq_push          = !oq_full;
        oq_data.kind     = KIND_DIAL;
        oq_data.byte_out = rd_data_r;
        oq_data.last     = lastd && (seg_from(POS_MSG, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                                              msg_r != MSG_NONE, post_r) == ST_IDLE);
        if (!oq_full) begin
          if (lastd) begin
            k_nxt     = 6'd0;
            state_nxt = seg_from(POS_MSG, pb_v_r, pc_v_r, dcnt_r != 6'd0,
                                 msg_r != MSG_NONE, post_r);
          end else begin
            k_nxt     = k_r + 6'd1;
            state_nxt = ST_DREQ;
          end
        end
      end

      ST_MSG: begin
        oq_push          = !oq_full;
        oq_data.kind     = KIND_HOST;
        oq_data.byte_out = msg_char(msg_r, k_r[4:0]);
        oq_data.last     = lastm && !post_r;
        if (!oq_full) begin
          if (lastm) begin
            k_nxt     = 6'd0;
            state_nxt = post_r ? ST_POST : ST_IDLE;
          end else begin
            k_nxt = k_r + 6'd1;
          end
        end
      end

      ST_POST: begin
        oq_push      = !oq_full;
        oq_data.kind = KIND_HANGUP;
        oq_data.last = 1'b1;
        if (!oq_full) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      online_r <= 1'b0;
      ans_r    <= 1'b0;
      esc_r    <= 1'b0;
      rb_r     <= '{default: '0};
      rt_r     <= '{default: '0};
      guard_r  <= GUARD_RESET;
      rd_idx_r <= '0;
      pend_v_r <= 1'b0;
      stop_r   <= 1'b0;
      k_r      <= 6'd0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      online_r <= online_nxt;
      ans_r    <= ans_nxt;
      esc_r    <= esc_nxt;
      rb_r     <= rb_nxt;
      rt_r     <= rt_nxt;
      guard_r  <= guard_nxt;
      rd_idx_r <= rd_idx_nxt;
      pend_v_r <= pend_v_nxt;
      stop_r   <= stop_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    n_r        <= n_nxt;
    neff_r     <= neff_nxt;
    pfx_r      <= pfx_nxt;
    vp_st_r    <= vp_st_nxt;
    vp_pos_r   <= vp_pos_nxt;
    df_found_r <= df_found_nxt;
    df_r       <= df_nxt;
    dl_r       <= dl_nxt;
    jout_r     <= jout_nxt;
    jlok_r     <= jlok_nxt;
    pb_v_r     <= pb_v_nxt;
    pb_kind_r  <= pb_kind_nxt;
    pb_byte_r  <= pb_byte_nxt;
    pc_v_r     <= pc_v_nxt;
    pc_kind_r  <= pc_kind_nxt;
    dcnt_r     <= dcnt_nxt;
    msg_r      <= msg_nxt;
    post_r     <= post_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= line_mem[mem_raddr];
    end
  end

  `ATCMI_ASSERT_NOW(a_push_room, oq_push, !oq_full)
  `ATCMI_ASSERT_NEXT(a_last_idle, oq_push && oq_data.last, state_r == ST_IDLE)
  `ATCMI_ASSERT_NOW(a_dout_after_dreq, state_r == ST_DOUT,
                    $past(state_r) == ST_DREQ || $past(state_r) == ST_DOUT)

endmodule

[design/at_command_modem_interpreter.sv]
// Channel   Handshake          Payload
// input     push / full        in_action, in_data, in_now_ms, in_write_ok,
//                              in_dial_outcome, in_listen_ok
// result    empty / pop        out_kind, out_byte_out, out_last, out_carrier,
//                              out_ready_res, out_in_escape
// config    cfg_we             cfg_wdata (guard time, ms)
//
// Results of a request are pushed one at a time while the result queue has room;
// each dial byte is first read from the line memory (ST_DREQ), then pushed (ST_DOUT),
// as there is one line memory read port. A carriage return first scans the stored
// line, one entry per cycle, and decides the command before the first result.
// Reset is synchronous, active low; it clears the queues and modem state.
// A full result queue stalls the executor; the two-entry front queue keeps taking
// requests until it fills.
module at_command_modem_interpreter #(
  parameter int unsigned LINE_DEPTH = atcmi_pkg::LINE_DEPTH_DEF,
  parameter int unsigned TIME_BITS  = atcmi_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data,
  input  logic [31:0] in_now_ms,
  input  logic        in_write_ok,
  input  logic [1:0]  in_dial_outcome,
  input  logic        in_listen_ok,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_out,
  output logic        out_last,
  output logic        out_carrier,
  output logic        out_ready_res,
  output logic        out_in_escape,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import atcmi_pkg::*;

  logic job_valid, job_take;
  job_t job;
  logic oq_push, oq_full;
  res_t oq_data;
  res_t head;

  atcmi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_data         (in_data),
    .in_now_ms       (in_now_ms),
    .in_write_ok     (in_write_ok),
    .in_dial_outcome (in_dial_outcome),
    .in_listen_ok    (in_listen_ok),
    .job_valid       (job_valid),
    .job             (job),
    .job_take        (job_take)
  );

  atcmi_exec #(
    .LINE_DEPTH (LINE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .oq_push   (oq_push),
    .oq_data   (oq_data),
    .oq_full   (oq_full)
  );

  atcmi_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .oq_push (oq_push),
    .oq_data (oq_data),
    .oq_full (oq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_kind      = head.kind;
  assign out_byte_out  = head.byte_out;
  assign out_last      = head.last;
  assign out_carrier   = head.carrier;
  assign out_ready_res = head.ready_res;
  assign out_in_escape = head.in_escape;

endmodule
